// ----- rtl/sfd_pkg.sv -----
package sfd_pkg;

  // Frame layout: seven payload bytes followed by two check bytes.
  localparam int unsigned FrameLen   = 9;
  localparam int unsigned PayloadLen = 7;
  localparam int unsigned CountSat   = 10;
  localparam int unsigned CountW     = 4;

  // CRC-16/CCITT-FALSE constants.
  localparam logic [15:0] CheckInit = 16'hFFFF;
  localparam logic [15:0] CheckPoly = 16'h1021;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadLen   = 2'd1,
    StBadCheck = 2'd2
  } status_e;

  // One received byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_word_t;

  // One decoded frame result.
  typedef struct packed {
    status_e            status;
    logic [15:0]        node_id;
    logic signed [15:0] temperature;
    logic [15:0]        vibration;
    logic [7:0]         health;
  } out_word_t;

  // One byte of the CRC update, MSB first, unrolled over the eight bits.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CheckPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/sensor_frame_decoder_crc16.sv -----
// Channel   Direction  Signals                              Word
// in        input      in_valid_i / in_ready_o / in_word_i  one frame byte and end marker
// out       output     out_valid_o / out_ready_i / out_word_o  one decoded frame result
//
// The CRC update, byte capture and count for each byte are done in the cycle the
// byte is accepted, and the result register is loaded on the last byte.
// A result appears in the cycle after its last byte is accepted.
// The input is ready whenever the result register is empty or being read, so bytes
// flow back to back while the output is taken; a stalled result holds the input.
// Reset (rst_ni, asynchronous, active low) clears the frame state and the result valid.
module sensor_frame_decoder_crc16 (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sfd_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sfd_pkg::out_word_t   out_word_o
);
  import sfd_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [15:0]       crc_q, crc_d;
  logic [55:0]       payload_q, payload_d;
  logic [15:0]       rcheck_q, rcheck_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;
  logic              in_fire;
  logic              last_fire;
  logic [2:0]        pos;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_fire  = in_fire && in_word_i.frame_end;
  assign pos        = count_q[2:0];

  // Frame state update for the byte at the current position.
  always_comb begin
    crc_d     = crc_q;
    payload_d = payload_q;
    rcheck_d  = rcheck_q;
    count_d   = count_q;
    if (count_q inside {[0:PayloadLen-1]}) begin
      crc_d = crc_update(crc_q, in_word_i.data_byte);
      for (int i = 0; i < PayloadLen; i++) begin
        if (pos == 3'(i)) begin
          payload_d[55-8*i -: 8] = in_word_i.data_byte;
        end
      end
    end else if (count_q inside {[PayloadLen:FrameLen-1]}) begin
      rcheck_d = {rcheck_q[7:0], in_word_i.data_byte};
    end
    if (count_q < CountW'(CountSat)) begin
      count_d = count_q + CountW'(1);
    end
  end

  // Result for the last byte of a frame.
  always_comb begin
    out_word_d = '0;
    if (count_d != CountW'(FrameLen)) begin
      out_word_d.status = StBadLen;
    end else if (crc_d != rcheck_d) begin
      out_word_d.status = StBadCheck;
    end else begin
      out_word_d.status      = StOk;
      out_word_d.node_id     = payload_d[55:40];
      out_word_d.temperature = payload_d[39:24];
      out_word_d.vibration   = payload_d[23:8];
      out_word_d.health      = payload_d[7:0];
    end
  end

  // Result valid: set by a last byte, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (last_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Frame state registers; a last byte restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      crc_q       <= CheckInit;
      payload_q   <= '0;
      rcheck_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (last_fire) begin
        count_q   <= '0;
        crc_q     <= CheckInit;
        payload_q <= '0;
        rcheck_q  <= '0;
      end else if (in_fire) begin
        count_q   <= count_d;
        crc_q     <= crc_d;
        payload_q <= payload_d;
        rcheck_q  <= rcheck_d;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (last_fire) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The byte count saturates and never passes its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(CountSat))
    else $error("byte count above saturation limit");

  // A last byte restarts the frame state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_fire |=> (count_q == '0) && (crc_q == CheckInit) && (payload_q == '0))
    else $error("frame state not restarted after last byte");

  // A last byte always produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_fire |=> out_valid_o)
    else $error("missing result after last byte");

  // A rejected frame carries zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != StOk) |->
      (out_word_o.node_id == '0) && (out_word_o.temperature == '0) &&
      (out_word_o.vibration == '0) && (out_word_o.health == '0))
    else $error("rejected frame with nonzero fields");

endmodule
